FILE: hw/rtl/ple_pkg.sv
// Shared constants, codes and controller/datapath link types for the list engine.
package ple_pkg;

   // Geometry
   localparam int CAPACITY   = 64;
   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W      = 7;
   localparam int POS_W      = 7;
   localparam int DATA_W     = 32;
   localparam int ACT_W      = 4;
   localparam int STAT_W     = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Request actions
   localparam logic [ACT_W-1:0] ACT_CLEAR    = 4'd0;
   localparam logic [ACT_W-1:0] ACT_INSERT   = 4'd1;
   localparam logic [ACT_W-1:0] ACT_DELETE   = 4'd2;
   localparam logic [ACT_W-1:0] ACT_GET      = 4'd3;
   localparam logic [ACT_W-1:0] ACT_LOCATE   = 4'd4;
   localparam logic [ACT_W-1:0] ACT_PRIOR    = 4'd5;
   localparam logic [ACT_W-1:0] ACT_NEXT     = 4'd6;
   localparam logic [ACT_W-1:0] ACT_APPEND   = 4'd7;
   localparam logic [ACT_W-1:0] ACT_TRAVERSE = 4'd8;

   // Response status codes
   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd4;

   // Register indexes (byte address / 4)
   localparam logic [CSR_ADDR_W-3:0] REG_LOCATE_MODE = 1'b0;

   // Controller to datapath
   typedef struct packed {
      logic load;    // capture request beat
      logic start;   // set up the store walk
      logic run;     // walk is active
      logic finish;  // commit state change and emit final beat
   } ple_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic skip_walk;     // request needs no store walk
      logic walk_done;     // walk ends with the entry handled this cycle
      logic emit_in_walk;  // walk itself emits the beats
      logic out_free;      // output register can take a beat
   } ple_stat_type;

endpackage

FILE: hw/rtl/ple_if.sv
// Request and response channel interfaces of the list engine.
interface ple_req_if;
   import ple_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [ACT_W-1:0]         action;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, action, position, value, input ready);
   modport sink   (input valid, action, position, value, output ready);
endinterface

interface ple_rsp_if;
   import ple_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic signed [DATA_W-1:0] result_value;
   logic [POS_W-1:0]         found_position;
   logic [CNT_W-1:0]         list_length;
   logic                     list_empty;
   logic                     last;

   modport source (output valid, status, result_value, found_position, list_length,
                   list_empty, last, input ready);
   modport sink   (input valid, status, result_value, found_position, list_length,
                   list_empty, last, output ready);
endinterface

FILE: hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: ordered list of signed 32-bit values.
//
// Channels: req carries one request beat (action, position, value); rsp returns
// result beats (status, result_value, found_position, list_length, list_empty,
// last). Every action returns exactly one beat, except traverse, which returns
// one beat per entry with last set on the final one (a single beat on an empty
// list). The APB port holds the locate mode register at byte address 0.
// Timing: one request is handled at a time. A request is taken in the idle
// state and checked in the check state, then the element store is walked at one
// entry per cycle unless a traversal stalls (single read port, one read and one
// write per cycle), and the finish state commits the length and loads the
// result. Traverse skips the finish state unless the list is empty. Requests
// that skip the walk (clear, rejected requests, insert at the tail, searches on
// an empty list) go from the check state straight to the finish state.
// Reset empties the list (length zero) and clears the locate mode; store
// contents are left as they are. A stalled response is held in its output
// register; the next request is still taken, and its result waits until the
// register frees. A traversal pauses its walk while the receiver stalls.
module positional_list_engine (
   input  logic                           clock,
   input  logic                           reset,
   ple_req_if.sink                        req,
   ple_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ple_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ple_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ple_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import ple_pkg::*;

   ple_cmd_type  cmd;
   ple_stat_type stat;
   logic         locate_mode;

   // configuration registers
   ple_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .locate_mode (locate_mode)
   );

   // sequencer
   ple_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store and result path
   ple_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .locate_mode  (locate_mode),
      .req_action   (req.action),
      .req_position (req.position),
      .req_value    (req.value),
      .rsp          (rsp)
   );

endmodule

FILE: hw/rtl/ple_csr.sv
// APB-style configuration register block (locate mode).
module ple_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ple_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ple_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ple_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output logic                           locate_mode
);
   import ple_pkg::*;

   logic                      mode_ff;
   logic                      mode_in;
   logic [CSR_ADDR_W-3:0]     reg_idx;
   logic                      wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;

   // register write
   always_comb begin
      mode_in = mode_ff;
      if (wr_en && (reg_idx == REG_LOCATE_MODE)) begin
         mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_idx)
         REG_LOCATE_MODE: prdata = {{(CSR_DATA_W-1){1'b0}}, mode_ff};
         default:         prdata = '0;
      endcase
   end

   assign pready      = 1'b1;
   assign locate_mode = mode_ff;

endmodule

FILE: hw/rtl/ple_controller.sv
// Sequencing state machine: accept, check, walk the store, finish.
module ple_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ple_pkg::ple_stat_type stat,
   output ple_pkg::ple_cmd_type  cmd
);
   import ple_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_CHECK  = 4'b0010,
      S_WALK   = 4'b0100,
      S_FINISH = 4'b1000
   } ctl_state_type;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.skip_walk) begin
               state_in = S_FINISH;
            end else begin
               cmd.start = 1'b1;
               state_in  = S_WALK;
            end
         end
         S_WALK: begin
            cmd.run = 1'b1;
            if (stat.walk_done) begin
               // traversal has already sent its beats
               state_in = stat.emit_in_walk ? S_IDLE : S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/ple_datapath.sv
// Element store, length count, walk pipeline and response register.
module ple_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  ple_pkg::ple_cmd_type       cmd,
   output ple_pkg::ple_stat_type      stat,
   input  logic                       locate_mode,
   input  logic [ple_pkg::ACT_W-1:0]  req_action,
   input  logic [ple_pkg::POS_W-1:0]  req_position,
   input  logic [ple_pkg::DATA_W-1:0] req_value,
   ple_rsp_if.source                  rsp
);
   import ple_pkg::*;

   // element store
   logic [DATA_W-1:0] mem [CAPACITY];

   // request beat
   logic [ACT_W-1:0]  act_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [DATA_W-1:0] val_ff;

   // list length
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   // walk address side
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic              down_ff;

   // walk data side
   logic              q_vld_ff;
   logic              q_vld_in;
   logic [IDX_W-1:0]  q_idx_ff;
   logic              q_last_ff;
   logic [DATA_W-1:0] rd_data_ff;

   // search results
   logic              found_ff, found_in;
   logic              want_next_ff, want_next_in;
   logic [DATA_W-1:0] res_val_ff, res_val_in;
   logic [DATA_W-1:0] prev_ff, prev_in;
   logic [POS_W-1:0]  fpos_ff, fpos_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic [POS_W-1:0]  rsp_fpos_ff;
   logic [CNT_W-1:0]  rsp_len_ff;
   logic              rsp_empty_ff;
   logic              rsp_last_ff;

   // decode helpers
   logic              pos_ok_ins, pos_ok_get, full;
   logic [CNT_W-1:0]  walk_len;
   logic [IDX_W-1:0]  walk_start;
   logic              skip;

   // walk control
   logic              out_free, stall, adv, issue, proc;
   logic              eq, gt, hit_loc;
   logic              done, emit_walk;
   logic              wwr;
   logic [IDX_W-1:0]  waddr;

   // finish outcome
   logic [STAT_W-1:0] fin_status;
   logic [DATA_W-1:0] fin_value;
   logic [POS_W-1:0]  fin_fpos;
   logic              fwr;
   logic [IDX_W-1:0]  faddr;

   // store write port
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              emit;

   // capture request beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         pos_ff <= req_position;
         val_ff <= req_value;
      end
   end

   // position and capacity checks
   assign pos_ok_ins = (pos_ff != '0) && (pos_ff <= count_ff + CNT_W'(1));
   assign pos_ok_get = (pos_ff != '0) && (pos_ff <= count_ff);
   assign full       = (count_ff >= CNT_W'(CAPACITY));

   // walk range per action
   always_comb begin
      walk_len   = '0;
      walk_start = '0;
      skip       = 1'b1;
      case (act_ff) inside
         ACT_INSERT: begin
            walk_len   = count_ff + CNT_W'(1) - pos_ff;
            walk_start = IDX_W'(count_ff - CNT_W'(1));
            skip       = !pos_ok_ins || full || (walk_len == '0);
         end
         ACT_DELETE: begin
            walk_len   = count_ff + CNT_W'(1) - pos_ff;
            walk_start = IDX_W'(pos_ff - POS_W'(1));
            skip       = !pos_ok_get;
         end
         ACT_GET: begin
            walk_len   = CNT_W'(1);
            walk_start = IDX_W'(pos_ff - POS_W'(1));
            skip       = !pos_ok_get;
         end
         [ACT_LOCATE:ACT_TRAVERSE]: begin
            walk_len = count_ff;
            skip     = (count_ff == '0);
         end
         default: skip = 1'b1;
      endcase
   end

   // walk handshake: traversal stalls on a full response register
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign stall    = q_vld_ff && (act_ff == ACT_TRAVERSE) && !out_free;
   assign adv      = !stall;
   assign issue    = cmd.run && adv && (rem_ff != '0);
   assign proc     = cmd.run && adv && q_vld_ff;
   assign q_vld_in = cmd.run ? (adv ? issue : q_vld_ff) : 1'b0;

   // address side
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rd_idx_ff <= walk_start;
         rem_ff    <= walk_len;
         down_ff   <= (act_ff == ACT_INSERT);
      end else if (issue) begin
         rd_idx_ff <= down_ff ? rd_idx_ff - IDX_W'(1) : rd_idx_ff + IDX_W'(1);
         rem_ff    <= rem_ff - CNT_W'(1);
      end
   end

   // data side tags
   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else begin
         q_vld_ff <= q_vld_in;
      end
      if (issue) begin
         q_idx_ff  <= rd_idx_ff;
         q_last_ff <= (rem_ff == CNT_W'(1));
      end
   end

   // entry compare
   assign eq      = (rd_data_ff == val_ff);
   assign gt      = $signed(val_ff) > $signed(rd_data_ff);
   assign hit_loc = locate_mode ? gt : eq;

   // per-entry handling
   always_comb begin
      found_in     = found_ff;
      want_next_in = want_next_ff;
      res_val_in   = res_val_ff;
      fpos_in      = fpos_ff;
      prev_in      = prev_ff;
      done         = 1'b0;
      emit_walk    = 1'b0;
      wwr          = 1'b0;
      waddr        = '0;
      if (cmd.load || cmd.start) begin
         // clear at accept too, so a request that skips the walk sees no match
         found_in     = 1'b0;
         want_next_in = 1'b0;
         res_val_in   = '0;
         fpos_in      = '0;
      end else if (proc) begin
         prev_in = rd_data_ff;
         case (act_ff) inside
            ACT_INSERT: begin
               // shift one place up
               wwr   = 1'b1;
               waddr = q_idx_ff + IDX_W'(1);
               done  = q_last_ff;
            end
            ACT_DELETE: begin
               // first entry is the removed one, the rest shift down
               if (q_idx_ff == IDX_W'(pos_ff - POS_W'(1))) begin
                  res_val_in = rd_data_ff;
               end else begin
                  wwr   = 1'b1;
                  waddr = q_idx_ff - IDX_W'(1);
               end
               done = q_last_ff;
            end
            ACT_GET: begin
               res_val_in = rd_data_ff;
               done       = 1'b1;
            end
            ACT_LOCATE: begin
               if (hit_loc) begin
                  found_in = 1'b1;
                  fpos_in  = POS_W'(q_idx_ff) + POS_W'(1);
                  done     = 1'b1;
               end else begin
                  done = q_last_ff;
               end
            end
            ACT_PRIOR: begin
               if (eq) begin
                  done = 1'b1;
                  if (q_idx_ff != '0) begin
                     found_in   = 1'b1;
                     res_val_in = prev_ff;
                  end
               end else begin
                  done = q_last_ff;
               end
            end
            ACT_NEXT: begin
               if (want_next_ff) begin
                  found_in   = 1'b1;
                  res_val_in = rd_data_ff;
                  done       = 1'b1;
               end else if (eq) begin
                  // successor follows on the next beat unless this is the tail
                  done         = q_last_ff;
                  want_next_in = !q_last_ff;
               end else begin
                  done = q_last_ff;
               end
            end
            ACT_APPEND: begin
               if (eq) begin
                  found_in = 1'b1;
                  done     = 1'b1;
               end else begin
                  done = q_last_ff;
               end
            end
            ACT_TRAVERSE: begin
               emit_walk = 1'b1;
               done      = q_last_ff;
            end
            default: done = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      found_ff     <= found_in;
      want_next_ff <= want_next_in;
      res_val_ff   <= res_val_in;
      fpos_ff      <= fpos_in;
      prev_ff      <= prev_in;
   end

   // final outcome and length update
   always_comb begin
      fin_status = ST_OK;
      fin_value  = '0;
      fin_fpos   = '0;
      count_in   = count_ff;
      fwr        = 1'b0;
      faddr      = '0;
      case (act_ff) inside
         ACT_CLEAR: count_in = '0;
         ACT_INSERT: begin
            if (!pos_ok_ins) begin
               fin_status = ST_BADPOS;
            end else if (full) begin
               fin_status = ST_FULL;
            end else begin
               fwr      = 1'b1;
               faddr    = IDX_W'(pos_ff - POS_W'(1));
               count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_DELETE: begin
            if (!pos_ok_get) begin
               fin_status = ST_BADPOS;
            end else begin
               fin_value = res_val_ff;
               count_in  = count_ff - CNT_W'(1);
            end
         end
         ACT_GET: begin
            if (!pos_ok_get) begin
               fin_status = ST_BADPOS;
            end else begin
               fin_value = res_val_ff;
            end
         end
         ACT_LOCATE: begin
            if (found_ff) begin
               fin_fpos = fpos_ff;
            end else begin
               fin_status = ST_NOTFOUND;
            end
         end
         ACT_PRIOR, ACT_NEXT: begin
            if (found_ff) begin
               fin_value = res_val_ff;
            end else begin
               fin_status = ST_NOTFOUND;
            end
         end
         ACT_APPEND: begin
            if (found_ff) begin
               fin_status = ST_PRESENT;
            end else if (full) begin
               fin_status = ST_FULL;
            end else begin
               fwr      = 1'b1;
               faddr    = IDX_W'(count_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_TRAVERSE: fin_status = ST_NOTFOUND;  // only reached on an empty list
         default: fin_status = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.finish) begin
         count_ff <= count_in;
      end
   end

   // store port: one write, one registered read per cycle
   assign wr_en   = (proc && wwr) || (cmd.finish && fwr);
   assign wr_addr = cmd.finish ? faddr : waddr;
   assign wr_data = cmd.finish ? val_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   // response register
   assign emit         = (proc && emit_walk) || cmd.finish;
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.finish) begin
         rsp_status_ff <= fin_status;
         rsp_value_ff  <= fin_value;
         rsp_fpos_ff   <= fin_fpos;
         rsp_len_ff    <= count_in;
         rsp_empty_ff  <= (count_in == '0);
         rsp_last_ff   <= 1'b1;
      end else if (emit) begin
         rsp_status_ff <= ST_OK;
         rsp_value_ff  <= rd_data_ff;
         rsp_fpos_ff   <= '0;
         rsp_len_ff    <= count_ff;
         rsp_empty_ff  <= (count_ff == '0);
         rsp_last_ff   <= q_last_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.result_value   = rsp_value_ff;
   assign rsp.found_position = rsp_fpos_ff;
   assign rsp.list_length    = rsp_len_ff;
   assign rsp.list_empty     = rsp_empty_ff;
   assign rsp.last           = rsp_last_ff;

   // status to controller
   assign stat.skip_walk    = skip;
   assign stat.walk_done    = proc && done;
   assign stat.emit_in_walk = (act_ff == ACT_TRAVERSE);
   assign stat.out_free     = out_free;

endmodule

FILE: hw/rtl/ple_checker.sv
// Port-level checks of the list engine, bound to the top level.
module ple_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ple_pkg::STAT_W-1:0]  rsp_status,
   input logic [ple_pkg::DATA_W-1:0]  rsp_result_value,
   input logic [ple_pkg::POS_W-1:0]   rsp_found_position,
   input logic [ple_pkg::CNT_W-1:0]   rsp_list_length,
   input logic                        rsp_list_empty,
   input logic                        rsp_last
);
   import ple_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_result_value) && $stable(rsp_found_position) &&
         $stable(rsp_list_length) && $stable(rsp_last))
      else $error("response beat changed while stalled");

   // one request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // empty flag agrees with the length
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_list_empty == (rsp_list_length == '0)))
      else $error("empty flag disagrees with list length");

   // only traversal beats come without last, and those carry status OK, a nonzero length and no position
   a_mid_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_status == ST_OK) && (rsp_list_length != '0) &&
         (rsp_found_position == '0))
      else $error("non-final beat with bad status or length");

   // length never passes capacity
   a_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_list_length <= CNT_W'(CAPACITY))
      else $error("list length above capacity");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_status         (rsp.status),
   .rsp_result_value   (rsp.result_value),
   .rsp_found_position (rsp.found_position),
   .rsp_list_length    (rsp.list_length),
   .rsp_list_empty     (rsp.list_empty),
   .rsp_last           (rsp.last)
);
